@@ design/sab_pkg.sv @@
// ----------------------------------------------------------------------------
// sab_pkg: shared constants and types for the sorted array binary search core
// Store geometry, beat field layout and the controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none

package sab_pkg;

    // store geometry
    localparam int SAB_DEPTH  = 1024;
    localparam int SAB_ADDR_W = $clog2(SAB_DEPTH);
    localparam int SAB_CNT_W  = SAB_ADDR_W + 1;
    localparam int SAB_WORD_W = 32;

    // input beat fields
    localparam int SAB_IDX_W   = 10;
    localparam int SAB_VAL_W   = 32;
    localparam int SAB_RANGE_W = 11;

    localparam int SAB_IDX_LSB   = 0;
    localparam int SAB_VAL_LSB   = SAB_IDX_LSB + SAB_IDX_W;
    localparam int SAB_START_LSB = SAB_VAL_LSB + SAB_VAL_W;
    localparam int SAB_END_LSB   = SAB_START_LSB + SAB_RANGE_W;
    localparam int SAB_TGT_LSB   = SAB_END_LSB + SAB_RANGE_W;
    localparam int SAB_S_BITS    = SAB_TGT_LSB + SAB_VAL_W;
    localparam int SAB_S_TDATA_W = ((SAB_S_BITS + 7) / 8) * 8;

    // output beat fields
    localparam int SAB_M_TDATA_W = ((SAB_IDX_W + 7) / 8) * 8;

    // tuser codes on the input side
    localparam logic SAB_CMD_LOAD   = 1'b0;
    localparam logic SAB_CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic write;     // store the load beat
        logic start;     // capture range and target of a search beat
        logic read;      // read the store at the computed probe index
        logic probe;     // narrow the range from the last probe
        logic res_hit;   // record a match at the last probe
        logic res_miss;  // record an empty range
        logic out_load;  // move the result into the output register
    } t_sab_cmd;

    typedef struct packed {
        logic range_empty;
        logic hit;
        logic out_free;
    } t_sab_status;

endpackage

`default_nettype wire

@@ design/sab_datapath.sv @@
// ----------------------------------------------------------------------------
// sab_datapath: store, search range registers and result registers
// Holds the word store, narrows [lo, hi) from each probe and drives the
// output beat register.
// ----------------------------------------------------------------------------
`default_nettype none

module sab_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sab_pkg::t_sab_cmd                 i_cmd,
    output sab_pkg::t_sab_status              o_status,
    input  logic [sab_pkg::SAB_S_TDATA_W-1:0] i_s_tdata,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic                              o_m_found,
    output logic [sab_pkg::SAB_IDX_W-1:0]     o_m_idx
);
    import sab_pkg::*;

    logic signed [SAB_WORD_W-1:0] r_mem [SAB_DEPTH];

    logic        [SAB_IDX_W-1:0]   w_entry_idx;
    logic        [SAB_VAL_W-1:0]   w_entry_val;
    logic        [SAB_RANGE_W-1:0] w_start;
    logic        [SAB_RANGE_W-1:0] w_end;
    logic signed [SAB_VAL_W-1:0]   w_tgt;

    logic        [SAB_CNT_W-1:0]   w_lo_init;
    logic        [SAB_CNT_W-1:0]   w_hi_init;

    logic        [SAB_CNT_W-1:0]   r_lo;
    logic        [SAB_CNT_W-1:0]   r_hi;
    logic signed [SAB_WORD_W-1:0]  r_target;
    logic signed [SAB_WORD_W-1:0]  r_rd;
    logic        [SAB_ADDR_W-1:0]  r_q;

    logic                          w_lt;
    logic        [SAB_CNT_W-1:0]   w_step_lo;
    logic        [SAB_CNT_W-1:0]   w_step_hi;
    logic        [SAB_CNT_W-1:0]   w_sel_lo;
    logic        [SAB_CNT_W-1:0]   w_sel_hi;
    logic        [SAB_CNT_W:0]     w_sum;
    logic        [SAB_ADDR_W-1:0]  w_q;

    logic                          r_found;
    logic        [SAB_IDX_W-1:0]   r_idx;
    logic                          r_m_valid;
    logic                          r_m_found;
    logic        [SAB_IDX_W-1:0]   r_m_idx;

    assign w_entry_idx = i_s_tdata[SAB_IDX_LSB +: SAB_IDX_W];
    assign w_entry_val = i_s_tdata[SAB_VAL_LSB +: SAB_VAL_W];
    assign w_start     = i_s_tdata[SAB_START_LSB +: SAB_RANGE_W];
    assign w_end       = i_s_tdata[SAB_END_LSB +: SAB_RANGE_W];
    assign w_tgt       = signed'(i_s_tdata[SAB_TGT_LSB +: SAB_VAL_W]);

    // clamp both range bounds to the store depth
    assign w_lo_init = (w_start > SAB_RANGE_W'(SAB_DEPTH)) ? SAB_CNT_W'(SAB_DEPTH)
                                                            : SAB_CNT_W'(w_start);
    assign w_hi_init = (w_end > SAB_RANGE_W'(SAB_DEPTH)) ? SAB_CNT_W'(SAB_DEPTH)
                                                          : SAB_CNT_W'(w_end);

    // narrow the range from the word read at the last probe
    assign w_lt      = r_target < r_rd;
    assign w_step_lo = w_lt ? r_lo : SAB_CNT_W'(r_q) + SAB_CNT_W'(1);
    assign w_step_hi = w_lt ? SAB_CNT_W'(r_q) : r_hi;
    assign w_sel_lo  = i_cmd.probe ? w_step_lo : r_lo;
    assign w_sel_hi  = i_cmd.probe ? w_step_hi : r_hi;

    // probe at floor((lo + hi - 1) / 2); only used while lo < hi
    assign w_sum = {1'b0, w_sel_lo} + {1'b0, w_sel_hi} - (SAB_CNT_W + 1)'(1);
    assign w_q   = w_sum[SAB_ADDR_W:1];

    assign o_status.range_empty = !(w_sel_lo < w_sel_hi);
    assign o_status.hit         = (r_rd == r_target);
    assign o_status.out_free    = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && (int'(w_entry_idx) < SAB_DEPTH)) begin
            r_mem[w_entry_idx[SAB_ADDR_W-1:0]] <= signed'(SAB_WORD_W'(w_entry_val));
        end
        if (i_cmd.read) begin
            r_rd <= r_mem[w_q];
            r_q  <= w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_lo     <= w_lo_init;
            r_hi     <= w_hi_init;
            r_target <= SAB_WORD_W'(w_tgt);
        end else if (i_cmd.probe) begin
            r_lo <= w_step_lo;
            r_hi <= w_step_hi;
        end
        if (i_cmd.res_hit) begin
            r_found <= 1'b1;
            r_idx   <= SAB_IDX_W'(r_q);
        end else if (i_cmd.res_miss) begin
            r_found <= 1'b0;
            r_idx   <= '0;
        end
        if (i_cmd.out_load) begin
            r_m_found <= r_found;
            r_m_idx   <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_found  = r_m_found;
    assign o_m_idx    = r_m_idx;

endmodule

`default_nettype wire

@@ design/sab_controller.sv @@
// ----------------------------------------------------------------------------
// sab_controller: sequencer for load and search beats
// Accepts beats while idle, steps the datapath one probe per cycle and hands
// the result to the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sab_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tuser,
    output logic                 o_s_tready,
    input  sab_pkg::t_sab_status i_status,
    output sab_pkg::t_sab_cmd    o_cmd
);
    import sab_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_ISSUE  = 2'd1;
    localparam logic [1:0] ST_PROBE  = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_s_tuser == SAB_CMD_SEARCH)) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_ISSUE;
                end else if (w_accept) begin
                    o_cmd.write = 1'b1;
                end
            end
            ST_ISSUE: begin
                if (i_status.range_empty) begin
                    o_cmd.res_miss = 1'b1;
                    n_state        = ST_RESULT;
                end else begin
                    o_cmd.read = 1'b1;
                    n_state    = ST_PROBE;
                end
            end
            ST_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_status.hit) begin
                    o_cmd.res_hit = 1'b1;
                    n_state       = ST_RESULT;
                end else if (i_status.range_empty) begin
                    o_cmd.res_miss = 1'b1;
                    n_state        = ST_RESULT;
                end else begin
                    // issue the next probe straight from the narrowed range
                    o_cmd.read = 1'b1;
                end
            end
            ST_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ design/sorted_array_binary_search_core.sv @@
// ----------------------------------------------------------------------------
// sorted_array_binary_search_core: binary search over a store of signed words
// Load beats fill a 1024-entry word store; search beats look up a target in
// a half-open index range of it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: tuser selects the beat kind (0 = load, 1 = search).
//   A load writes entry_value at entry_index and returns nothing. A search
//   returns one beat on m_axis: tuser = found, tdata = match index (0 when
//   not found). Entries must be loaded before a search probes them.
// Timing:
//   A load leaves the input open; the next beat may follow at once.
//   A search passes an accept step, a range check step, one probe step per
//   store read (at most 11 probes for a 1024-entry range) and a hand-off step;
//   the single store read port issues one probe per cycle.
//   The result appears on m_axis the cycle after the hand-off.
// Reset: synchronous, active low; clears the sequencer and the output valid.
//   The store itself is not cleared.
// Stall: a result waits in the output register while m_axis_tready is low;
//   loads and a further search are still taken, and a search that finishes
//   meanwhile holds until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_binary_search_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // entry_index, entry_value, range_start, range_end, target
    input  logic [sab_pkg::SAB_S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // match_index
    output logic [sab_pkg::SAB_M_TDATA_W-1:0] m_axis_tdata,
    // found
    output logic                              m_axis_tuser
);
    import sab_pkg::*;

    t_sab_cmd              w_cmd;
    t_sab_status           w_status;
    logic [SAB_IDX_W-1:0]  w_m_idx;

    sab_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sab_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_s_tdata  (s_axis_tdata),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_found  (m_axis_tuser),
        .o_m_idx    (w_m_idx)
    );

    assign m_axis_tdata = SAB_M_TDATA_W'(w_m_idx);

endmodule

`default_nettype wire

@@ design/sab_checker.sv @@
// ----------------------------------------------------------------------------
// sab_checker: port-level checks for the binary search core
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
`default_nettype none

module sab_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tvalid,
    input wire                              s_axis_tready,
    input wire [sab_pkg::SAB_S_TDATA_W-1:0] s_axis_tdata,
    input wire                              s_axis_tuser,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [sab_pkg::SAB_M_TDATA_W-1:0] m_axis_tdata,
    input wire                              m_axis_tuser
);
    import sab_pkg::*;

    // output valid is cleared by reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("m_axis_tvalid high after reset");

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped under stall");

    // a miss carries a zero index
    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("nonzero index on a miss");

    // a search beat occupies the sequencer for the next cycle
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == SAB_CMD_SEARCH)
        |=> !s_axis_tready)
        else $error("beat taken right after a search beat");

    // a load beat leaves the input open
    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == SAB_CMD_LOAD)
        |=> s_axis_tready)
        else $error("input closed after a load beat");

endmodule

bind sorted_array_binary_search_core sab_checker u_sab_checker (.*);

`default_nettype wire

@@ tb/sab_search_checker.sv @@
// ----------------------------------------------------------------------------
// sab_search_checker: result checker for the sorted array binary search core
// Mirrors the word store from accepted load beats, predicts the outcome of
// each accepted search beat and compares every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sab_search_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    // entry_index, entry_value, range_start, range_end, target
    input  logic [sab_pkg::SAB_S_TDATA_W-1:0] i_s_tdata,
    // cmd
    input  logic                              i_s_tuser,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    // match_index
    input  logic [sab_pkg::SAB_M_TDATA_W-1:0] i_m_tdata,
    // found
    input  logic                              i_m_tuser,
    output int                                o_mismatch_count,
    output int                                o_outstanding
);
    import sab_pkg::*;

    typedef struct {
        logic                  found;
        logic [SAB_ADDR_W-1:0] match_index;
    } t_search_outcome;

    int              word_image [SAB_DEPTH];
    t_search_outcome outcome_q[$];

    initial begin
        o_mismatch_count = 0;
        o_outstanding    = 0;
        foreach (word_image[i]) word_image[i] = 0;
    end

    // halve [lo, hi) with the probe at floor((lo + hi - 1) / 2)
    function automatic t_search_outcome lookup_outcome(input logic [SAB_RANGE_W-1:0] lo_in,
                                                       input logic [SAB_RANGE_W-1:0] hi_in,
                                                       input int tgt);
        t_search_outcome res;
        int              lo;
        int              hi;
        int              mid;
        bit              done;
        res.found       = 1'b0;
        res.match_index = '0;
        lo   = (lo_in > SAB_DEPTH) ? SAB_DEPTH : int'(lo_in);
        hi   = (hi_in > SAB_DEPTH) ? SAB_DEPTH : int'(hi_in);
        done = 1'b0;
        while (!done && lo < hi) begin
            mid = (lo + hi - 1) / 2;
            if (word_image[mid] == tgt) begin
                res.found       = 1'b1;
                res.match_index = mid[SAB_ADDR_W-1:0];
                done            = 1'b1;
            end else if (tgt < word_image[mid]) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_search_outcome exp_o;
        logic [SAB_M_TDATA_W-1:0] exp_data;
        if (i_rst_n) begin
            // results first: a result never belongs to a search taken this edge
            if (i_m_tvalid && i_m_tready) begin
                if (outcome_q.size() == 0) begin
                    if (o_mismatch_count < 10)
                        $display("%0t: result beat with none pending: found=%0b index=%0d",
                                 $realtime, i_m_tuser, i_m_tdata);
                    o_mismatch_count = o_mismatch_count + 1;
                end else begin
                    exp_o    = outcome_q.pop_front();
                    exp_data = '0;
                    exp_data[SAB_ADDR_W-1:0] = exp_o.match_index;
                    if (i_m_tuser !== exp_o.found || i_m_tdata !== exp_data) begin
                        if (o_mismatch_count < 10)
                            $display("%0t: mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                                     $realtime, exp_o.found, exp_o.match_index,
                                     i_m_tuser, i_m_tdata);
                        o_mismatch_count = o_mismatch_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == SAB_CMD_LOAD) begin
                    word_image[i_s_tdata[SAB_IDX_LSB +: SAB_IDX_W]] =
                        int'(i_s_tdata[SAB_VAL_LSB +: SAB_VAL_W]);
                end else begin
                    outcome_q.push_back(lookup_outcome(i_s_tdata[SAB_START_LSB +: SAB_RANGE_W],
                                                       i_s_tdata[SAB_END_LSB +: SAB_RANGE_W],
                                                       int'(i_s_tdata[SAB_TGT_LSB +: SAB_VAL_W])));
                end
            end
            o_outstanding = outcome_q.size();
        end
    end

endmodule

@@ tb/tb_sorted_array_binary_search_core.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_array_binary_search_core: testbench for the binary search core
// Directed loads and searches over a small sorted store, then a full sorted
// fill and a random mix of mostly order-keeping loads and searches, with random
// gaps on the input and back-pressure on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_array_binary_search_core;
    import sab_pkg::*;

    localparam int RANDOM_ITEMS = 105;
    localparam int CALM_ITEMS   = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int WORD_MIN     = 32'sh8000_0000;
    localparam int WORD_MAX     = 32'sh7FFF_FFFF;

    logic                     i_clk;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // entry_index, entry_value, range_start, range_end, target
    logic [SAB_S_TDATA_W-1:0] s_axis_tdata  = '0;
    // cmd
    logic                     s_axis_tuser  = SAB_CMD_LOAD;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b1;
    // match_index
    logic [SAB_M_TDATA_W-1:0] m_axis_tdata;
    // found
    logic                     m_axis_tuser;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;
    bit calm        = 1'b0;
    int stall_left  = 0;
    int shadow [SAB_DEPTH];

    sorted_array_binary_search_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sab_search_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (s_axis_tvalid),
        .i_s_tready       (s_axis_tready),
        .i_s_tdata        (s_axis_tdata),
        .i_s_tuser        (s_axis_tuser),
        .i_m_tvalid       (m_axis_tvalid),
        .i_m_tready       (m_axis_tready),
        .i_m_tdata        (m_axis_tdata),
        .i_m_tuser        (m_axis_tuser),
        .o_mismatch_count (mismatch_count),
        .o_outstanding    (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_sorted_array_binary_search_core: errors");
            $finish;
        end
    end

    // output back-pressure in random bursts
    always @(negedge i_clk) begin
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left    <= $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // unused fields carry random bits
    function automatic logic [SAB_S_TDATA_W-1:0] noise_bits();
        logic [SAB_S_TDATA_W-1:0] d;
        d = {$urandom, $urandom, $urandom};
        return d;
    endfunction

    task automatic send_beat(input logic cmd, input logic [SAB_S_TDATA_W-1:0] data);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = data;
        s_axis_tuser  = cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic load_word(input int idx, input int val);
        logic [SAB_S_TDATA_W-1:0] d;
        d = noise_bits();
        d[SAB_IDX_LSB +: SAB_IDX_W] = idx[SAB_IDX_W-1:0];
        d[SAB_VAL_LSB +: SAB_VAL_W] = val;
        shadow[idx] = val;
        send_beat(SAB_CMD_LOAD, d);
    endtask

    task automatic search_word(input int lo, input int hi, input int tgt);
        logic [SAB_S_TDATA_W-1:0] d;
        d = noise_bits();
        d[SAB_START_LSB +: SAB_RANGE_W] = lo[SAB_RANGE_W-1:0];
        d[SAB_END_LSB +: SAB_RANGE_W]   = hi[SAB_RANGE_W-1:0];
        d[SAB_TGT_LSB +: SAB_VAL_W]     = tgt;
        send_beat(SAB_CMD_SEARCH, d);
    endtask

    // keep order where the neighbors allow it, but now and then, or where they do not, scatter a wild value
    task automatic random_load();
        int          idx;
        int          lw;
        int          up;
        longint      span;
        int unsigned off;
        idx = $urandom_range(0, SAB_DEPTH - 1);
        lw  = (idx > 0) ? shadow[idx - 1] : WORD_MIN;
        up  = (idx < SAB_DEPTH - 1) ? shadow[idx + 1] : WORD_MAX;
        if ($urandom_range(0, 3) != 0 && lw <= up) begin
            span = longint'(up) - longint'(lw);
            off  = $urandom_range(0, span[31:0]);
            load_word(idx, int'(longint'(lw) + longint'(off)));
        end else begin
            load_word(idx, int'($urandom));
        end
    endtask

    task automatic random_search();
        int pick;
        int lo;
        int hi;
        int lo_c;
        int hi_c;
        int k;
        int tgt;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            lo = 0;
            hi = SAB_DEPTH;
        end else if (pick < 22) begin
            lo = $urandom_range(0, 2047);
            hi = $urandom_range(0, 2047);
        end else if (pick < 30) begin
            lo = $urandom_range(0, SAB_DEPTH);
            hi = $urandom_range(0, lo);
        end else if (pick < 55) begin
            lo = $urandom_range(0, SAB_DEPTH - 1);
            hi = lo + $urandom_range(1, 4);
            if (hi > SAB_DEPTH) hi = SAB_DEPTH;
        end else begin
            lo = $urandom_range(0, SAB_DEPTH - 1);
            hi = $urandom_range(lo + 1, SAB_DEPTH);
        end
        lo_c = (lo > SAB_DEPTH) ? SAB_DEPTH : lo;
        hi_c = (hi > SAB_DEPTH) ? SAB_DEPTH : hi;
        k    = (lo_c < hi_c) ? $urandom_range(lo_c, hi_c - 1) : $urandom_range(0, SAB_DEPTH - 1);
        pick = $urandom_range(0, 99);
        if (pick < 55)      tgt = shadow[k];
        else if (pick < 65) tgt = shadow[k] + 1;
        else if (pick < 75) tgt = shadow[k] - 1;
        else if (pick < 80) tgt = WORD_MIN;
        else if (pick < 85) tgt = WORD_MAX;
        else                tgt = int'($urandom);
        search_word(lo, hi, tgt);
    endtask

    initial begin
        longint acc;
        foreach (shadow[i]) shadow[i] = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // small sorted store at the bottom, extremes at both ends
        load_word(0, WORD_MIN);
        load_word(1, -5);
        load_word(2, -1);
        load_word(3, 0);
        load_word(4, 1);
        load_word(5, 7);
        load_word(6, 100);
        load_word(7, WORD_MAX);
        search_word(0, 8, WORD_MIN);
        search_word(0, 8, WORD_MAX);
        search_word(0, 8, 0);
        search_word(0, 8, 2);
        search_word(1, 8, WORD_MIN);
        search_word(0, 7, WORD_MAX);
        search_word(4, 5, 1);
        search_word(5, 2, 0);
        search_word(3, 3, 0);
        // ranges past the end of the store clamp to it
        search_word(SAB_DEPTH, 2047, 0);
        search_word(2047, 0, 7);
        load_word(SAB_DEPTH - 1, 42);
        search_word(SAB_DEPTH - 1, 2047, 42);

        // fill the whole store in ascending order, with duplicates
        acc = WORD_MIN;
        for (int i = 0; i < SAB_DEPTH; i++) begin
            if (i == SAB_DEPTH - 1) acc = WORD_MAX;
            load_word(i, int'(acc));
            if ($urandom_range(0, 9) != 0) acc = acc + $urandom_range(1, 1 << 22);
            if (acc > WORD_MAX) acc = WORD_MAX;
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 9) < 4) random_load();
            else                          random_search();
        end
        s_axis_tvalid = 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatch_count == 0 && outstanding == 0) begin
            $display("tb_sorted_array_binary_search_core: clean");
        end else begin
            $display("tb_sorted_array_binary_search_core: errors");
        end
        $finish;
    end

endmodule

@@ sorted_array_binary_search_core.f @@
design/sab_pkg.sv
design/sab_datapath.sv
design/sab_controller.sv
design/sorted_array_binary_search_core.sv
design/sab_checker.sv
tb/sab_search_checker.sv
tb/tb_sorted_array_binary_search_core.sv
